// File: sv/spq_pkg.sv
// Shared types, constants and helpers for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OCC_W    = 5;

  localparam logic [1:0] ST_PUSHED = 2'd0;
  localparam logic [1:0] ST_POPPED = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [CNT_W-1:0] count_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } spq_ctrl_t;

  // Occupancy is reported modulo the width of the output field.
  function automatic logic [OCC_W-1:0] occ_of(input count_t c);
    logic [CNT_W+OCC_W-1:0] w;
    w = {{OCC_W{1'b0}}, c};
    return w[OCC_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/spq_cell.sv
// One cell of the sorted chain: holds an entry and trades it with its neighbors.
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire spq_ctrl_t ctrl,
  input  wire logic      occupied,
  input  wire word_t     new_value,
  input  wire word_t     new_priority,
  input  wire logic      left_ahead,
  input  wire word_t     left_value,
  input  wire word_t     left_priority,
  input  wire word_t     right_value,
  input  wire word_t     right_priority,
  output word_t          value,
  output word_t          priority_q,
  output logic           ahead
);

  // The new entry belongs at or ahead of this cell when the cell is empty or
  // holds a strictly lower priority, so equal priorities stay in arrival order.
  assign ahead = !occupied || (priority_q < new_priority);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      if (left_ahead) begin
        value      <= left_value;
        priority_q <= left_priority;
      end else if (ahead) begin
        value      <= new_value;
        priority_q <= new_priority;
      end
    end else if (ctrl.pop) begin
      value      <= right_value;
      priority_q <= right_priority;
    end
  end

endmodule
`default_nettype wire

// File: sv/sorted_priority_queue.sv
// Top level of the sorted priority queue built as a chain of cells.
// The queue holds up to CAPACITY entries sorted by descending signed priority,
// oldest first among equal priorities, one entry per cell. Every request is
// handled in parallel: all cells compare their priority with the pushed
// one at once and each shifts, loads or holds in the same edge, so a push or
// pop is accepted each cycle the result register is free or being taken.
// Each request gives one result with status, popped value and occupancy.
`default_nettype none
module sorted_priority_queue
  import spq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              req_type,
  input  wire word_t             item_value,
  input  wire word_t             item_priority,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             status,
  output word_t                  popped_value,
  output logic [OCC_W-1:0]       occupancy
);

  count_t    count;
  count_t    count_next;
  spq_ctrl_t ctrl;
  logic      accept;
  logic      full;
  logic      empty;
  logic [1:0] status_next;

  word_t cell_value    [CAPACITY];
  word_t cell_priority [CAPACITY];
  logic  cell_ahead    [CAPACITY];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == count_t'(CAPACITY));
  assign empty    = (count == '0);

  assign ctrl.push = accept && (req_type == REQ_PUSH) && !full;
  assign ctrl.pop  = accept && (req_type == REQ_POP) && !empty;

  always_comb begin
    count_next = count;
    if (ctrl.push) begin
      count_next = count + count_t'(1);
    end else if (ctrl.pop) begin
      count_next = count - count_t'(1);
    end
    if (req_type == REQ_PUSH) begin
      status_next = full ? ST_FULL : ST_PUSHED;
    end else begin
      status_next = empty ? ST_EMPTY : ST_POPPED;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  left_ahead;
    word_t left_value;
    word_t left_priority;
    word_t right_value;
    word_t right_priority;

    if (i == 0) begin : g_head
      assign left_ahead    = 1'b0;
      assign left_value    = item_value;
      assign left_priority = item_priority;
    end else begin : g_mid
      assign left_ahead    = cell_ahead[i-1];
      assign left_value    = cell_value[i-1];
      assign left_priority = cell_priority[i-1];
    end

    // The tail cell refills with its own contents on a pop; it becomes empty.
    if (i == CAPACITY - 1) begin : g_tail
      assign right_value    = cell_value[i];
      assign right_priority = cell_priority[i];
    end else begin : g_body
      assign right_value    = cell_value[i+1];
      assign right_priority = cell_priority[i+1];
    end

    spq_cell u_cell (
      .clk            (clk),
      .ctrl           (ctrl),
      .occupied       (count_t'(i) < count),
      .new_value      (item_value),
      .new_priority   (item_priority),
      .left_ahead     (left_ahead),
      .left_value     (left_value),
      .left_priority  (left_priority),
      .right_value    (right_value),
      .right_priority (right_priority),
      .value          (cell_value[i]),
      .priority_q     (cell_priority[i]),
      .ahead          (cell_ahead[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= status_next;
      popped_value <= ctrl.pop ? cell_value[0] : '0;
      occupancy    <= occ_of(count_next);
    end
  end

endmodule
`default_nettype wire
